/* hw/rtl/heightmap_box_smoother_macros.svh */
// Assertion macros for the heightmap smoother RTL.
// Included by hbs_back, the module that carries concurrent checks; needs nothing else.
`ifndef HEIGHTMAP_BOX_SMOOTHER_MACROS_SVH
`define HEIGHTMAP_BOX_SMOOTHER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HBS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("heightmap_box_smoother: assertion failed");

// Condition that must never be true outside reset.
`define HBS_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("heightmap_box_smoother: forbidden condition seen");

`endif

/* hw/rtl/hbs_pkg.sv */
// Types and constants of the heightmap smoother.
// Used by every module of the block but hbs_ram; depends on nothing.
`timescale 1ns / 1ps

package hbs_pkg;

  // Internal coordinate width: holds any row or column up to 4096.
  localparam int unsigned COORD_W = 13;
  // Linear position width: row * width + column plus the window lag.
  localparam int unsigned LIN_W = 27;
  // Ring row index width: holds the index of a ring of up to 8 rows.
  localparam int unsigned RING_W = 3;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN = 2'd2;

  localparam logic [10:0] RST_FRAME_WIDTH = 11'd1024;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd1024;
  localparam logic [15:0] RST_HEIGHT_GAIN = 16'd803;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic [7:0]  average;
    logic [23:0] scaled_height;
    logic        frame_last;
  } out_item_t;

  // Work handed from the front to the back.
  typedef struct packed {
    logic               wr;
    logic [7:0]         pixel;
    logic [RING_W-1:0]  wr_ring;
    logic [COORD_W-1:0] wr_col;
    logic               emit;
    logic [COORD_W-1:0] e_col;
    logic [COORD_W-1:0] e_row;
    logic [RING_W-1:0]  e_ring;
    logic               last;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PRE,
    F_WR,
    F_POST,
    F_DEC
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WR,
    B_RD,
    B_ACC,
    B_DIV,
    B_MUL
  } back_state_e;

endpackage

/* hw/rtl/hbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
`timescale 1ns / 1ps

module hbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/hbs_front.sv */
// Front end: accepts items, tracks input and result positions and classifies
// each item into a store write and/or a result job. Depends on hbs_pkg.
`timescale 1ns / 1ps

module hbs_front #(
  parameter int unsigned WINDOW_RADIUS = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hbs_pkg::in_item_t           in_item_i,
  input  logic [hbs_pkg::COORD_W-1:0] width_i,
  input  logic [hbs_pkg::COORD_W-1:0] height_i,
  input  logic                        full_i,
  output logic                        push_o,
  output hbs_pkg::job_t               job_o
);

  localparam int unsigned RING_ROWS = 2 * WINDOW_RADIUS + 2;
  localparam int unsigned CW = hbs_pkg::COORD_W;
  localparam int unsigned LW = hbs_pkg::LIN_W;
  localparam int unsigned RW = hbs_pkg::RING_W;

  hbs_pkg::front_state_e state_q, state_d;
  logic [CW-1:0] in_col_q, in_col_d, in_row_q, in_row_d;
  logic [CW-1:0] e_col_q, e_col_d, e_row_q, e_row_d;
  logic [RW-1:0] in_ring_q, in_ring_d, e_ring_q, e_ring_d;
  logic          done_q, done_d;
  logic          op_q, op_d, wr_q, wr_d;
  logic [7:0]    pix_q, pix_d;
  logic [RW-1:0] wr_ring_q, wr_ring_d;
  logic [CW-1:0] wr_col_q, wr_col_d;
  logic [LW-1:0] in_lin_q, in_lin_d, e_lin_q, e_lin_d, total_q, total_d;
  logic          emit, last;
  logic [CW:0]   col_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hbs_pkg::F_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_ring_q <= '0;
      e_col_q   <= '0;
      e_row_q   <= '0;
      e_ring_q  <= '0;
      done_q    <= 1'b0;
      wr_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_ring_q <= in_ring_d;
      e_col_q   <= e_col_d;
      e_row_q   <= e_row_d;
      e_ring_q  <= e_ring_d;
      done_q    <= done_d;
      wr_q      <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pix_q     <= pix_d;
    wr_ring_q <= wr_ring_d;
    wr_col_q  <= wr_col_d;
    in_lin_q  <= in_lin_d;
    e_lin_q   <= e_lin_d;
    total_q   <= total_d;
  end

  // A result is due unless the frame is still filling and the window of
  // the next result reaches beyond what has arrived.
  assign emit = !((in_lin_q < total_q) &&
                  (e_lin_q + LW'(WINDOW_RADIUS) * LW'(width_i) + LW'(WINDOW_RADIUS)
                   >= in_lin_q));
  assign last = (e_lin_q + LW'(1)) >= total_q;
  assign col_inc = {1'b0, in_col_q} + (CW+1)'(1);

  always_comb begin
    state_d   = state_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_ring_d = in_ring_q;
    e_col_d   = e_col_q;
    e_row_d   = e_row_q;
    e_ring_d  = e_ring_q;
    done_d    = done_q;
    op_d      = op_q;
    pix_d     = pix_q;
    wr_d      = wr_q;
    wr_ring_d = wr_ring_q;
    wr_col_d  = wr_col_q;
    in_lin_d  = in_lin_q;
    e_lin_d   = e_lin_q;
    total_d   = total_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      hbs_pkg::F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = in_item_i.op;
          pix_d = in_item_i.pixel;
          if (done_q && in_item_i.op == hbs_pkg::OP_DRAIN) begin
            state_d = hbs_pkg::F_IDLE;
          end else begin
            if (done_q) begin
              // A pixel after a finished frame opens the next frame.
              in_col_d  = '0;
              in_row_d  = '0;
              in_ring_d = '0;
              e_col_d   = '0;
              e_row_d   = '0;
              e_ring_d  = '0;
              done_d    = 1'b0;
            end
            state_d = hbs_pkg::F_PRE;
          end
        end
      end
      hbs_pkg::F_PRE: begin
        in_lin_d = LW'(in_row_q) * LW'(width_i) + LW'(in_col_q);
        total_d  = LW'(width_i) * LW'(height_i);
        state_d  = hbs_pkg::F_WR;
      end
      hbs_pkg::F_WR: begin
        wr_d      = (op_q == hbs_pkg::OP_PIXEL) && (in_lin_q < total_q);
        wr_ring_d = in_ring_q;
        wr_col_d  = in_col_q;
        if (wr_d) begin
          if (col_inc >= {1'b0, width_i}) begin
            in_col_d  = '0;
            in_row_d  = in_row_q + CW'(1);
            in_ring_d = (in_ring_q == RW'(RING_ROWS - 1)) ? '0 : in_ring_q + RW'(1);
          end else begin
            in_col_d = col_inc[CW-1:0];
          end
        end
        state_d = hbs_pkg::F_POST;
      end
      hbs_pkg::F_POST: begin
        in_lin_d = LW'(in_row_q) * LW'(width_i) + LW'(in_col_q);
        e_lin_d  = LW'(e_row_q) * LW'(width_i) + LW'(e_col_q);
        state_d  = hbs_pkg::F_DEC;
      end
      hbs_pkg::F_DEC: begin
        if (!(wr_q || emit)) begin
          state_d = hbs_pkg::F_IDLE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = hbs_pkg::F_IDLE;
          if (emit) begin
            if ({1'b0, e_col_q} + (CW+1)'(1) >= {1'b0, width_i}) begin
              e_col_d  = '0;
              e_row_d  = e_row_q + CW'(1);
              e_ring_d = (e_ring_q == RW'(RING_ROWS - 1)) ? '0 : e_ring_q + RW'(1);
            end else begin
              e_col_d = e_col_q + CW'(1);
            end
            if (last) begin
              done_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = hbs_pkg::F_IDLE;
      end
    endcase
  end

  always_comb begin
    job_o.wr      = wr_q;
    job_o.pixel   = pix_q;
    job_o.wr_ring = wr_ring_q;
    job_o.wr_col  = wr_col_q;
    job_o.emit    = emit;
    job_o.e_col   = e_col_q;
    job_o.e_row   = e_row_q;
    job_o.e_ring  = e_ring_q;
    job_o.last    = last;
  end

endmodule

/* hw/rtl/hbs_fifo.sv */
// Two-entry job queue between the front and the back.
// Depends on hbs_pkg for the job type.
`timescale 1ns / 1ps

module hbs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hbs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hbs_pkg::job_t job_o
);

  hbs_pkg::job_t entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = entry_q[rptr_q];

endmodule

/* hw/rtl/hbs_back.sv */
// Back end: writes pixels into the line store, sums the in-frame window,
// divides by the neighbour count, scales and holds the result for transfer.
// Depends on hbs_pkg, hbs_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "heightmap_box_smoother_macros.svh"

module hbs_back #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned WINDOW_RADIUS = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  hbs_pkg::job_t               job_i,
  output logic                        pop_o,
  input  logic [hbs_pkg::COORD_W-1:0] width_i,
  input  logic [hbs_pkg::COORD_W-1:0] height_i,
  input  logic [15:0]                 gain_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output hbs_pkg::out_item_t          out_item_o
);

  localparam int unsigned RING_ROWS = 2 * WINDOW_RADIUS + 2;
  localparam int unsigned DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned WIN = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned DW = $clog2(WIN);
  localparam int unsigned CNT_W = $clog2(WIN * WIN + 1);
  localparam int unsigned SUM_W = CNT_W + 8;
  localparam int unsigned DIV_W = SUM_W + 8;
  localparam int unsigned CW = hbs_pkg::COORD_W;
  localparam int unsigned RW = hbs_pkg::RING_W;

  hbs_pkg::back_state_e state_q, state_d;
  hbs_pkg::job_t      job_q, job_d;
  logic [CW:0]        row_q, row_d;
  logic [RW-1:0]      ring_q, ring_d;
  logic [DW-1:0]      dx_q, dx_d, dy_q, dy_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [DIV_W-1:0]   rem_q, rem_d;
  logic [7:0]         quo_q, quo_d;
  logic [2:0]         bit_q, bit_d;
  logic               out_valid_q, out_valid_d;
  hbs_pkg::out_item_t out_q, out_d;

  logic [CW:0]      col_s;
  logic [RW:0]      ring_start;
  logic             in_frame;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;
  logic [DIV_W-1:0] trial;
  logic [7:0]       avg;

  hbs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(job_q.pixel),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbs_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    row_q  <= row_d;
    ring_q <= ring_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sum_q  <= sum_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  assign col_s = {1'b0, job_q.e_col} + (CW+1)'(dx_q) - (CW+1)'(WINDOW_RADIUS);
  assign in_frame = !row_q[CW] && (row_q[CW-1:0] < height_i) &&
                    !col_s[CW] && (col_s[CW-1:0] < width_i);
  assign ring_start = {1'b0, job_q.e_ring} + (RW+1)'(RING_ROWS - WINDOW_RADIUS);
  assign ram_waddr = AW'(job_q.wr_ring) * AW'(MAX_WIDTH) + AW'(job_q.wr_col);
  assign ram_raddr = AW'(ring_q) * AW'(MAX_WIDTH) + AW'(col_s[CW-1:0]);
  assign trial = DIV_W'(cnt_q) << bit_q;
  assign avg = (cnt_q == '0) ? 8'd0 : quo_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    row_d       = row_q;
    ring_d      = ring_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    // Read data lands in the cycle after its request.
    sum_d       = sum_q + (pend_q ? SUM_W'(ram_rdata) : '0);
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      hbs_pkg::B_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          state_d = hbs_pkg::B_WR;
        end
      end
      hbs_pkg::B_WR: begin
        ram_we = job_q.wr;
        if (job_q.emit) begin
          row_d   = {1'b0, job_q.e_row} - (CW+1)'(WINDOW_RADIUS);
          ring_d  = (ring_start >= (RW+1)'(RING_ROWS)) ?
                    RW'(ring_start - (RW+1)'(RING_ROWS)) : RW'(ring_start);
          dx_d    = '0;
          dy_d    = '0;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = hbs_pkg::B_RD;
        end else begin
          state_d = hbs_pkg::B_IDLE;
        end
      end
      hbs_pkg::B_RD: begin
        ram_re = in_frame;
        if (in_frame) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (dx_q == DW'(WIN - 1)) begin
          dx_d   = '0;
          dy_d   = dy_q + DW'(1);
          row_d  = row_q + (CW+1)'(1);
          ring_d = (ring_q == RW'(RING_ROWS - 1)) ? '0 : ring_q + RW'(1);
          if (dy_q == DW'(WIN - 1)) begin
            state_d = hbs_pkg::B_ACC;
          end
        end else begin
          dx_d = dx_q + DW'(1);
        end
      end
      hbs_pkg::B_ACC: begin
        rem_d   = DIV_W'(sum_d);
        quo_d   = '0;
        bit_d   = 3'd7;
        state_d = hbs_pkg::B_DIV;
      end
      hbs_pkg::B_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_q >= trial) begin
          rem_d        = rem_q - trial;
          quo_d[bit_q] = 1'b1;
        end
        bit_d = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          state_d = hbs_pkg::B_MUL;
        end
      end
      hbs_pkg::B_MUL: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.out_col       = job_q.e_col[9:0];
          out_d.out_row       = job_q.e_row[11:0];
          out_d.average       = avg;
          out_d.scaled_height = 24'(avg) * 24'(gain_i);
          out_d.frame_last    = job_q.last;
          out_valid_d         = 1'b1;
          state_d             = hbs_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = hbs_pkg::B_IDLE;
      end
    endcase
  end

  assign pend_d      = ram_re;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `HBS_NEVER(a_single_port_use, clk_i, rst_ni, ram_we && ram_re)
  `HBS_ASSERT(a_result_from_mul, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == hbs_pkg::B_MUL))
  `HBS_ASSERT(a_sum_bounded, clk_i, rst_ni, (state_q != hbs_pkg::B_DIV) || (rem_q < (trial << 1)) || (bit_q == 3'd7))

endmodule

/* hw/rtl/heightmap_box_smoother.sv */
// Top level of the edge-normalized heightmap box smoother.
// Depends on hbs_pkg, hbs_front, hbs_fifo and hbs_back.
//
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-------------------------------
// in      | input     | in_valid_i/ready_o  | in_item_i  (op, pixel)
// out     | output    | out_valid_o/ready_i | out_item_o (col, row, avg, ...)
// cfg     | input     | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//
// The front end takes an input transfer only in F_IDLE, then places it through
// F_PRE (multiply), F_WR (decide), F_POST (multiply) and F_DEC (decide).
// The back end owns both line store ports and never uses them together; a result
// takes a pop, a write, (2*WINDOW_RADIUS+1)^2 window reads, a drain state, the
// bit-wise division in B_DIV and a scale in B_MUL, which waits on the output.
// Reset is asynchronous and active low; it clears positions and queues, the
// line store keeps no reset value and needs no clearing pass.
// A stalled output holds the back end; the two-entry job queue lets the
// front end keep taking transfers until that queue fills.
`timescale 1ns / 1ps

module heightmap_box_smoother #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned WINDOW_RADIUS = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  hbs_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output hbs_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned CW = hbs_pkg::COORD_W;

  logic [10:0]   frame_width_q;
  logic [12:0]   frame_height_q;
  logic [15:0]   height_gain_q;
  logic [CW-1:0] width_used, height_used;

  logic          q_push, q_full, q_pop, q_valid;
  hbs_pkg::job_t front_job, back_job;

  // Configuration writes are always taken; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= hbs_pkg::RST_FRAME_WIDTH;
      frame_height_q <= hbs_pkg::RST_FRAME_HEIGHT;
      height_gain_q  <= hbs_pkg::RST_HEIGHT_GAIN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hbs_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[10:0];
        hbs_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[12:0];
        hbs_pkg::CFG_HEIGHT_GAIN:  height_gain_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sizes are used saturated: zero counts as one, and the width is capped at
  // the line store row length, the height at the largest frame.
  always_comb begin
    if (frame_width_q == '0) begin
      width_used = CW'(1);
    end else if (CW'(frame_width_q) > CW'(MAX_WIDTH)) begin
      width_used = CW'(MAX_WIDTH);
    end else begin
      width_used = CW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_used = CW'(1);
    end else if (CW'(frame_height_q) > CW'(hbs_pkg::MAX_HEIGHT)) begin
      height_used = CW'(hbs_pkg::MAX_HEIGHT);
    end else begin
      height_used = CW'(frame_height_q);
    end
  end

  hbs_front #(
    .WINDOW_RADIUS(WINDOW_RADIUS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .width_i   (width_used),
    .height_i  (height_used),
    .full_i    (q_full),
    .push_o    (q_push),
    .job_o     (front_job)
  );

  hbs_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (front_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .job_o  (back_job)
  );

  hbs_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .WINDOW_RADIUS(WINDOW_RADIUS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (back_job),
    .pop_o      (q_pop),
    .width_i    (width_used),
    .height_i   (height_used),
    .gain_i     (height_gain_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
